@@ hdl/avg_pool_2d_window_assert.svh @@
// ----------------------------------------------------------------------------
// avg_pool_2d_window assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AVG_POOL_2D_WINDOW_ASSERT_SVH
`define AVG_POOL_2D_WINDOW_ASSERT_SVH
`ifndef SYNTH
// Property check, held off during reset
`define APW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next
`define APW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define APW_ASSERT(lbl, clk, rst, prop, msg)
`define APW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ hdl/apw_pkg.sv @@
// ----------------------------------------------------------------------------
// apw_pkg
// Shared types, codes and constants of the 2-D average pooling block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apw_pkg;

  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_KERNEL_DEF = 8;

  localparam int COORD_W = 12;          // signed window coordinate
  localparam int CNT_W   = 8;           // window pixel count, up to 15 x 15
  localparam int SAMPLE_W = 16;
  localparam int SUM_W   = SAMPLE_W + CNT_W;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } apw_op_t;

  typedef enum logic [2:0] {
    REG_PLANE_HEIGHT  = 3'd0,
    REG_PLANE_WIDTH   = 3'd1,
    REG_KERNEL_HEIGHT = 3'd2,
    REG_KERNEL_WIDTH  = 3'd3,
    REG_STRIDE_ROWS   = 3'd4,
    REG_STRIDE_COLS   = 3'd5,
    REG_PAD_TOP       = 3'd6,
    REG_PAD_LEFT      = 3'd7
  } apw_reg_t;

  typedef struct packed {
    apw_op_t              op;
    logic [5:0]           pixel_row;
    logic [5:0]           pixel_col;
    logic signed [15:0]   pixel_value;
    logic [5:0]           out_row;
    logic [5:0]           out_col;
    logic                 include_pad;
  } apw_req_t;

  typedef struct packed {
    logic signed [15:0]   average;
    logic [6:0]           in_plane_count;
  } apw_rsp_t;

  typedef struct packed {
    logic [2:0]           index;
    logic [6:0]           data;
  } apw_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic store;
    logic start;
    logic walk;
    logic div_init;
    logic div_step;
    logic load;
  } apw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_last;
    logic div_last;
    logic out_busy;
  } apw_sts_t;

endpackage

@@ hdl/apw_stream_if.sv @@
// ----------------------------------------------------------------------------
// apw_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface apw_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ hdl/avg_pool_2d_window.sv @@
// ----------------------------------------------------------------------------
// avg_pool_2d_window
// Write item: stored at the accepting edge.
// Compute item: after accept the window is walked one pixel per cycle (a zero kernel
//   dimension walks the other one), then drain, divider set-up and shift-subtract divide;
//   the result loads when the result register is free, next item taken the cycle after.
// One item in flight; the result register frees the input side.
// Synchronous active-high reset: config to defaults, store contents undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module avg_pool_2d_window #(
  parameter int MAX_HEIGHT = apw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = apw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = apw_pkg::MAX_KERNEL_DEF
) (
  input logic          clk,
  input logic          rst,
  apw_stream_if.sink   request,
  apw_stream_if.source result,
  apw_stream_if.sink   cfg
);

  import apw_pkg::*;

  apw_cmd_t cmd;
  apw_sts_t sts;
  apw_req_t req;
  apw_cfg_t cfg_data;
  apw_rsp_t rsp;
  logic     rsp_valid;

  assign req      = request.payload;
  assign cfg_data = cfg.payload;
  assign cfg.ready = 1'b1;

  apw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_op    (req.op),
    .req_ready (request.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  apw_datapath #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (rsp_valid),
    .out_ready (result.ready),
    .out_data  (rsp)
  );

  assign result.valid   = rsp_valid;
  assign result.payload = rsp;

endmodule

@@ hdl/apw_ram.sv @@
// ----------------------------------------------------------------------------
// apw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/apw_ctrl.sv @@
// ----------------------------------------------------------------------------
// apw_ctrl
// Sequencer: accepts items, walks the window, runs the divider, loads result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "avg_pool_2d_window_assert.svh"

module apw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  apw_pkg::apw_op_t  req_op,
  output logic              req_ready,
  output apw_pkg::apw_cmd_t cmd,
  input  apw_pkg::apw_sts_t sts
);

  import apw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_PREP,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid && req_op == OP_COMPUTE) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (sts.walk_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN:  state <= ST_PREP;
        ST_PREP:   state <= ST_DIVIDE;
        ST_DIVIDE: begin
          if (sts.div_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!sts.out_busy) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.store    = (state == ST_IDLE) && req_valid && (req_op == OP_WRITE);
    cmd.start    = (state == ST_IDLE) && req_valid && (req_op == OP_COMPUTE);
    cmd.walk     = (state == ST_WALK);
    cmd.div_init = (state == ST_PREP);
    cmd.div_step = (state == ST_DIVIDE);
    cmd.load     = (state == ST_FINISH) && !sts.out_busy;
  end

  `APW_ASSERT(a_cmd_onehot, clk, rst, $onehot0(cmd), "more than one datapath command")
  `APW_ASSERT_NEXT(a_start_walk, clk, rst, cmd.start, state == ST_WALK, "start not followed by walk")
  `APW_ASSERT(a_init_after_drain, clk, rst, (cmd.div_init |-> $past(state) == ST_DRAIN), "divider set up before last read landed")

endmodule

@@ hdl/apw_datapath.sv @@
// ----------------------------------------------------------------------------
// apw_datapath
// Config registers, pixel store, window address walk, accumulator,
// shift-subtract divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "avg_pool_2d_window_assert.svh"

module apw_datapath #(
  parameter int MAX_HEIGHT = apw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = apw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = apw_pkg::MAX_KERNEL_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  apw_pkg::apw_req_t req,
  input  logic              cfg_valid,
  input  apw_pkg::apw_cfg_t cfg_data,
  input  apw_pkg::apw_cmd_t cmd,
  output apw_pkg::apw_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output apw_pkg::apw_rsp_t out_data
);

  import apw_pkg::*;

  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // configuration
  logic [6:0] plane_height, plane_width;
  logic [3:0] kernel_height, kernel_width, stride_rows, stride_cols;
  logic [2:0] pad_top, pad_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height  <= 7'd1;
      plane_width   <= 7'd1;
      kernel_height <= 4'd1;
      kernel_width  <= 4'd1;
      stride_rows   <= 4'd1;
      stride_cols   <= 4'd1;
      pad_top       <= 3'd0;
      pad_left      <= 3'd0;
    end else if (cfg_valid) begin
      case (apw_reg_t'(cfg_data.index))
        REG_PLANE_HEIGHT:  plane_height  <= cfg_data.data;
        REG_PLANE_WIDTH:   plane_width   <= cfg_data.data;
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data.data[3:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data.data[3:0];
        REG_STRIDE_ROWS:   stride_rows   <= cfg_data.data[3:0];
        REG_STRIDE_COLS:   stride_cols   <= cfg_data.data[3:0];
        REG_PAD_TOP:       pad_top       <= cfg_data.data[2:0];
        REG_PAD_LEFT:      pad_left      <= cfg_data.data[2:0];
        default: ;
      endcase
    end
  end

  // saturated plane and kernel sizes
  logic signed [COORD_W-1:0] ph, pw;
  logic [3:0] kh, kw;

  assign ph = (COORD_W'(plane_height) > COORD_W'(MAX_HEIGHT)) ?
              $signed(COORD_W'(MAX_HEIGHT)) : $signed(COORD_W'(plane_height));
  assign pw = (COORD_W'(plane_width) > COORD_W'(MAX_WIDTH)) ?
              $signed(COORD_W'(MAX_WIDTH)) : $signed(COORD_W'(plane_width));
  assign kh = (5'(kernel_height) > 5'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kernel_height;
  assign kw = (5'(kernel_width) > 5'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : kernel_width;

  // window origin, latched with the compute item
  logic [9:0] row_prod, col_prod;
  logic signed [COORD_W-1:0] win_top, win_left;
  logic [CNT_W-1:0] den_full;
  logic incl;
  logic [3:0] ky, kx;

  assign row_prod = 10'(req.out_row) * 10'(stride_rows);
  assign col_prod = 10'(req.out_col) * 10'(stride_cols);

  logic signed [COORD_W-1:0] iy, ix;
  logic in_window, in_plane, row_done;

  assign iy = win_top + $signed(COORD_W'(ky));
  assign ix = win_left + $signed(COORD_W'(kx));
  assign in_window = (ky < kh) && (kx < kw);
  assign in_plane = in_window && !iy[COORD_W-1] && (iy < ph) && !ix[COORD_W-1] && (ix < pw);
  assign row_done = (5'(kx) + 5'd1) >= 5'(kw);

  assign sts.walk_last = row_done && ((5'(ky) + 5'd1) >= 5'(kh));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      win_top  <= $signed(COORD_W'(row_prod)) - $signed(COORD_W'(pad_top));
      win_left <= $signed(COORD_W'(col_prod)) - $signed(COORD_W'(pad_left));
      incl     <= req.include_pad;
      ky       <= '0;
      kx       <= '0;
    end else if (cmd.walk) begin
      if (row_done) begin
        kx <= '0;
        ky <= ky + 4'd1;
      end else begin
        kx <= kx + 4'd1;
      end
    end
  end

  // pixel store
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   rd_data;
  logic          rd_en;

  assign wr_en = cmd.store && (32'(req.pixel_row) < MAX_HEIGHT) &&
                 (32'(req.pixel_col) < MAX_WIDTH);
  assign wr_addr = AW'(req.pixel_row) * AW'(MAX_WIDTH) + AW'(req.pixel_col);
  assign rd_en = cmd.walk && in_plane;
  assign rd_addr = AW'(iy[RW-1:0]) * AW'(MAX_WIDTH) + AW'(ix[CW-1:0]);

  apw_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (req.pixel_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // accumulate in the cycle after the read
  logic rd_hit;
  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit   <= 1'b0;
      cnt      <= '0;
      den_full <= '0;
    end else if (cmd.start) begin
      rd_hit   <= 1'b0;
      cnt      <= '0;
      den_full <= CNT_W'(kh) * CNT_W'(kw);
    end else begin
      rd_hit <= rd_en;
      if (rd_hit) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum <= '0;
    end else if (rd_hit) begin
      sum <= sum + SUM_W'($signed(rd_data));
    end
  end

  // restoring divider on the magnitude, one quotient bit per cycle
  logic [CNT_W-1:0] den_sel, div_den, div_rem, rem_next;
  logic [SUM_W-1:0] div_quo;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic div_neg;
  logic [CNT_W:0] shifted;
  logic fits;

  assign den_sel = incl ? den_full : cnt;
  assign shifted = {div_rem, div_quo[SUM_W-1]};
  assign fits = shifted >= {1'b0, div_den};
  assign rem_next = fits ? CNT_W'(shifted - {1'b0, div_den}) : shifted[CNT_W-1:0];
  assign sts.div_last = (div_cnt == DIV_CNT_W'(SUM_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_den <= (den_sel == '0) ? CNT_W'(1) : den_sel;
      div_rem <= '0;
      div_quo <= sum[SUM_W-1] ? SUM_W'(-sum) : sum;
      div_neg <= sum[SUM_W-1];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= rem_next;
      div_quo <= {div_quo[SUM_W-2:0], fits};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // signed quotient with saturation guard
  logic signed [SUM_W:0] q;
  logic signed [15:0] q_sat;

  assign q = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign q_sat = (q > $signed((SUM_W+1)'(32767))) ? 16'sh7fff :
                 (q < -$signed((SUM_W+1)'(32768))) ? 16'sh8000 : q[15:0];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data.average        <= q_sat;
      out_data.in_plane_count <= cnt[6:0];
    end
  end

  assign sts.out_busy = out_valid && !out_ready;

  `APW_ASSERT(a_cnt_bound, clk, rst, (cnt <= den_full), "in-plane count above kernel area")
  `APW_ASSERT(a_rem_bound, clk, rst, (cmd.div_step |-> div_rem < div_den), "divider remainder out of range")
  `APW_ASSERT_NEXT(a_load_valid, clk, rst, cmd.load, out_valid, "loaded result not presented")

endmodule

@@ sim/tb_avg_pool_2d_window.sv @@
// ----------------------------------------------------------------------------
// tb_avg_pool_2d_window
// Self-checking bench for the 2-D average pooling block. Pixels go into the
// store and window averages are requested over valid/ready channels, with
// random gaps on both sides. A local copy of the store and the geometry
// registers predicts every average and in-plane count. Windows are only
// requested once all of their in-plane pixels hold written data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_avg_pool_2d_window;
  import apw_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int STORE_ROWS   = MAX_HEIGHT_DEF;
  localparam int STORE_COLS   = MAX_WIDTH_DEF;
  localparam int KERNEL_MAX   = MAX_KERNEL_DEF;
  localparam int SETTLE_CYC   = 100;   // above the 8 x 8 walk plus divider
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASES       = 12;

  typedef struct {
    logic [6:0] plane_height;
    logic [6:0] plane_width;
    logic [3:0] kernel_height;
    logic [3:0] kernel_width;
    logic [3:0] stride_rows;
    logic [3:0] stride_cols;
    logic [2:0] pad_top;
    logic [2:0] pad_left;
  } pool_cfg_t;

  typedef struct {
    int rows;
    int cols;
    int krows;
    int kcols;
    int top;
    int left;
  } window_geom_t;

  logic clk;
  logic rst;

  apw_stream_if #(.payload_t(apw_req_t)) req_ch ();
  apw_stream_if #(.payload_t(apw_rsp_t)) rsp_ch ();
  apw_stream_if #(.payload_t(apw_cfg_t)) cfg_ch ();

  avg_pool_2d_window u_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (rsp_ch),
    .cfg     (cfg_ch)
  );

  logic signed [15:0] pixel_shadow [STORE_ROWS*STORE_COLS];
  bit                 pixel_known  [STORE_ROWS*STORE_COLS];
  pool_cfg_t          cfg_shadow;
  apw_rsp_t           expected_avgs [$];

  bit          gaps_on;
  bit          req_hot;
  bit          cfg_hot;
  int          stall_left;
  int          idle_cycles;
  int unsigned fails;
  int unsigned n_writes;
  int unsigned n_computes;
  int unsigned n_results;
  int unsigned n_settings;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Window placement with the register saturation applied
  function automatic window_geom_t window_at(input logic [5:0] orow, input logic [5:0] ocol);
    window_geom_t g;
    g.rows  = (cfg_shadow.plane_height > STORE_ROWS) ? STORE_ROWS : cfg_shadow.plane_height;
    g.cols  = (cfg_shadow.plane_width > STORE_COLS) ? STORE_COLS : cfg_shadow.plane_width;
    g.krows = (cfg_shadow.kernel_height > KERNEL_MAX) ? KERNEL_MAX : cfg_shadow.kernel_height;
    g.kcols = (cfg_shadow.kernel_width > KERNEL_MAX) ? KERNEL_MAX : cfg_shadow.kernel_width;
    g.top   = int'(orow) * int'(cfg_shadow.stride_rows) - int'(cfg_shadow.pad_top);
    g.left  = int'(ocol) * int'(cfg_shadow.stride_cols) - int'(cfg_shadow.pad_left);
    return g;
  endfunction

  function automatic apw_rsp_t pooled_result(input logic [5:0] orow, input logic [5:0] ocol,
                                             input logic incl);
    window_geom_t g;
    apw_rsp_t     r;
    int           total;
    int           cnt;
    int           den;
    int           q;
    int           ky;
    int           kx;
    int           iy;
    int           ix;
    g = window_at(orow, ocol);
    total = 0;
    cnt = 0;
    for (ky = 0; ky < g.krows; ky++) begin
      iy = g.top + ky;
      if (iy >= 0 && iy < g.rows) begin
        for (kx = 0; kx < g.kcols; kx++) begin
          ix = g.left + kx;
          if (ix >= 0 && ix < g.cols) begin
            total += pixel_shadow[iy*STORE_COLS + ix];
            cnt++;
          end
        end
      end
    end
    den = incl ? g.krows * g.kcols : cnt;
    if (den < 1)
      den = 1;
    q = total / den;    // truncates toward zero
    if (q > 32767)
      q = 32767;
    if (q < -32768)
      q = -32768;
    r.average = q[15:0];
    r.in_plane_count = cnt[6:0];
    return r;
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [6:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return 7'($urandom());
      1, 2: return 7'($urandom_range(1, 64));
      default: return 7'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [6:0] pick_span();
    if ($urandom_range(0, 9) == 0)
      return 7'($urandom());
    return 7'($urandom_range(1, 8));
  endfunction

  // Valid is left high after a transaction; whoever pauses lowers it
  task automatic push_request(input apw_req_t item);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 4) == 0)
      gap = $urandom_range(1, 7);
    if (gap != 0 && req_hot) begin
      req_ch.valid <= 1'b0;
      req_hot = 1'b0;
    end
    repeat (gap) @(posedge clk);
    if (!req_hot) begin
      req_ch.valid <= 1'b1;
      req_hot = 1'b1;
    end
    req_ch.payload <= item;
    do @(posedge clk); while (!req_ch.ready);
    if (item.op == OP_WRITE) begin
      pixel_shadow[{item.pixel_row, item.pixel_col}] = item.pixel_value;
      pixel_known[{item.pixel_row, item.pixel_col}] = 1'b1;
      n_writes++;
    end else begin
      expected_avgs.push_back(pooled_result(item.out_row, item.out_col, item.include_pad));
      n_computes++;
    end
  endtask

  task automatic write_pixel(input logic [5:0] row, input logic [5:0] col,
                             input logic signed [15:0] value);
    apw_req_t item;
    item.op          = OP_WRITE;
    item.pixel_row   = row;
    item.pixel_col   = col;
    item.pixel_value = value;
    item.out_row     = 6'($urandom_range(0, 63));
    item.out_col     = 6'($urandom_range(0, 63));
    item.include_pad = 1'($urandom_range(0, 1));
    push_request(item);
  endtask

  // Any in-plane pixel not yet written gets a value first
  task automatic compute_window(input logic [5:0] orow, input logic [5:0] ocol,
                                input logic incl);
    window_geom_t g;
    apw_req_t     item;
    int           ky;
    int           kx;
    int           iy;
    int           ix;
    g = window_at(orow, ocol);
    for (ky = 0; ky < g.krows; ky++) begin
      iy = g.top + ky;
      for (kx = 0; kx < g.kcols; kx++) begin
        ix = g.left + kx;
        if (iy >= 0 && iy < g.rows && ix >= 0 && ix < g.cols &&
            !pixel_known[iy*STORE_COLS + ix])
          write_pixel(6'(iy), 6'(ix), pick_sample());
      end
    end
    item.op          = OP_COMPUTE;
    item.pixel_row   = 6'($urandom_range(0, 63));
    item.pixel_col   = 6'($urandom_range(0, 63));
    item.pixel_value = 16'($urandom());
    item.out_row     = orow;
    item.out_col     = ocol;
    item.include_pad = incl;
    push_request(item);
  endtask

  task automatic drain_results(input bit settle);
    if (req_hot) begin
      req_ch.valid <= 1'b0;
      req_hot = 1'b0;
      @(posedge clk);
    end
    while (expected_avgs.size() != 0) @(posedge clk);
    if (settle)
      repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input apw_reg_t idx, input logic [6:0] data);
    apw_cfg_t w;
    w.index = idx;
    w.data  = data;
    if (!cfg_hot) begin
      cfg_ch.valid <= 1'b1;
      cfg_hot = 1'b1;
    end
    cfg_ch.payload <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PLANE_HEIGHT:  cfg_shadow.plane_height  = data;
      REG_PLANE_WIDTH:   cfg_shadow.plane_width   = data;
      REG_KERNEL_HEIGHT: cfg_shadow.kernel_height = data[3:0];
      REG_KERNEL_WIDTH:  cfg_shadow.kernel_width  = data[3:0];
      REG_STRIDE_ROWS:   cfg_shadow.stride_rows   = data[3:0];
      REG_STRIDE_COLS:   cfg_shadow.stride_cols   = data[3:0];
      REG_PAD_TOP:       cfg_shadow.pad_top       = data[2:0];
      REG_PAD_LEFT:      cfg_shadow.pad_left      = data[2:0];
      default: ;
    endcase
  endtask

  // Only reprogrammed once the block has gone quiet
  task automatic apply_settings(input logic [6:0] ph, input logic [6:0] pw,
                                input logic [6:0] kh, input logic [6:0] kw,
                                input logic [6:0] sr, input logic [6:0] sc,
                                input logic [6:0] pt, input logic [6:0] pl);
    drain_results(1'b1);
    write_reg(REG_PLANE_HEIGHT, ph);
    write_reg(REG_PLANE_WIDTH, pw);
    write_reg(REG_KERNEL_HEIGHT, kh);
    write_reg(REG_KERNEL_WIDTH, kw);
    write_reg(REG_STRIDE_ROWS, sr);
    write_reg(REG_STRIDE_COLS, sc);
    write_reg(REG_PAD_TOP, pt);
    write_reg(REG_PAD_LEFT, pl);
    cfg_ch.valid <= 1'b0;
    cfg_hot = 1'b0;
    n_settings++;
  endtask

  task automatic test_reset_defaults();
    write_pixel(6'd0, 6'd0, 16'sh7FFF);
    compute_window(6'd0, 6'd0, 1'b0);
    compute_window(6'd0, 6'd1, 1'b1);      // outside a 1 x 1 plane
    compute_window(6'd63, 6'd63, 1'b0);
    write_pixel(6'd63, 6'd63, 16'sh8000);
  endtask

  task automatic test_sample_extremes();
    apply_settings(7'd64, 7'd64, 7'd1, 7'd2, 7'd1, 7'd1, 7'd0, 7'd0);
    write_pixel(6'd63, 6'd62, 16'sh8000);
    compute_window(6'd63, 6'd62, 1'b0);
    compute_window(6'd63, 6'd63, 1'b1);    // right column falls off the plane
    compute_window(6'd63, 6'd63, 1'b0);
    write_pixel(6'd0, 6'd0, -16'sd3);
    write_pixel(6'd0, 6'd1, -16'sd4);
    compute_window(6'd0, 6'd0, 1'b0);      // -7 / 2 truncates to -3
    write_pixel(6'd0, 6'd0, 16'sh7FFF);
    write_pixel(6'd0, 6'd1, 16'sh7FFF);
    compute_window(6'd0, 6'd0, 1'b1);
  endtask

  task automatic test_window_padding();
    apply_settings(7'd5, 7'd6, 7'd3, 7'd3, 7'd2, 7'd2, 7'd1, 7'd1);
    compute_window(6'd0, 6'd0, 1'b1);
    compute_window(6'd0, 6'd0, 1'b0);
    compute_window(6'd2, 6'd2, 1'b1);
    // window wholly inside the padding
    apply_settings(7'd8, 7'd8, 7'd7, 7'd7, 7'd1, 7'd1, 7'd7, 7'd7);
    compute_window(6'd0, 6'd0, 1'b1);
    compute_window(6'd0, 6'd0, 1'b0);
  endtask

  task automatic test_oversized_settings();
    // plane and kernel saturate; unused high data bits are dropped
    apply_settings(7'd127, 7'd65, 7'h7F, 7'h19, 7'h71, 7'd9, 7'h78, 7'h7B);
    compute_window(6'd62, 6'd7, 1'b0);
    compute_window(6'd62, 6'd7, 1'b1);
  endtask

  task automatic test_degenerate_settings();
    apply_settings(7'd0, 7'd10, 7'd2, 7'd2, 7'd1, 7'd1, 7'd0, 7'd0);
    compute_window(6'd0, 6'd0, 1'b1);
    apply_settings(7'd10, 7'd10, 7'd0, 7'd3, 7'd1, 7'd1, 7'd0, 7'd0);
    compute_window(6'd1, 6'd1, 1'b1);
    compute_window(6'd1, 6'd1, 1'b0);
    apply_settings(7'd10, 7'd10, 7'd3, 7'd0, 7'd1, 7'd1, 7'd0, 7'd0);
    compute_window(6'd1, 6'd1, 1'b1);
    // zero stride pins every window to minus the pad
    apply_settings(7'd10, 7'd10, 7'd2, 7'd2, 7'd0, 7'd0, 7'd1, 7'd0);
    compute_window(6'd37, 6'd51, 1'b0);
    compute_window(6'd0, 6'd0, 1'b1);
  endtask

  task automatic test_random_windows();
    window_geom_t g;
    int           phase;
    int unsigned  sent0;
    int           lim_r;
    int           lim_c;
    logic [5:0]   orow;
    logic [5:0]   ocol;
    logic [5:0]   row;
    logic [5:0]   col;
    for (phase = 0; phase < PHASES; phase++) begin
      gaps_on = (phase < PHASES - 2);
      if (phase == 0)
        apply_settings(7'd64, 7'd64, 7'd8, 7'd8, 7'd8, 7'd8, 7'd7, 7'd7);
      else if (phase == 1)
        apply_settings(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd0, 7'd0);
      else
        apply_settings(pick_dim(), pick_dim(), pick_span(), pick_span(), pick_span(),
                       pick_span(), 7'($urandom()), 7'($urandom()));
      g = window_at(6'd0, 6'd0);
      lim_r = (g.rows + int'(cfg_shadow.pad_top)) /
              ((cfg_shadow.stride_rows == 0) ? 1 : int'(cfg_shadow.stride_rows));
      lim_c = (g.cols + int'(cfg_shadow.pad_left)) /
              ((cfg_shadow.stride_cols == 0) ? 1 : int'(cfg_shadow.stride_cols));
      if (lim_r > 63)
        lim_r = 63;
      if (lim_c > 63)
        lim_c = 63;
      // budget counts every item sent, fill-in writes included
      sent0 = n_writes + n_computes;
      while (n_writes + n_computes - sent0 < RANDOM_ITEMS / PHASES) begin
        if (gaps_on && $urandom_range(0, 59) == 0)
          drain_results(1'b0);
        if ($urandom_range(0, 9) < 3) begin
          row = (g.rows > 0 && $urandom_range(0, 3) != 0) ?
                6'($urandom_range(0, g.rows - 1)) : 6'($urandom_range(0, 63));
          col = (g.cols > 0 && $urandom_range(0, 3) != 0) ?
                6'($urandom_range(0, g.cols - 1)) : 6'($urandom_range(0, 63));
          write_pixel(row, col, pick_sample());
        end else begin
          orow = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63)) :
                                               6'($urandom_range(0, lim_r));
          ocol = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63)) :
                                               6'($urandom_range(0, lim_c));
          compute_window(orow, ocol, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  // Result sink back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    apw_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_avgs.size() == 0) begin
        $error("unexpected result: average %0d, in_plane_count %0d",
               rsp_ch.payload.average, rsp_ch.payload.in_plane_count);
        fails++;
      end else begin
        want = expected_avgs.pop_front();
        n_results++;
        if (rsp_ch.payload.average !== want.average) begin
          $error("average: expected %0d, actual %0d", want.average, rsp_ch.payload.average);
          fails++;
        end
        if (rsp_ch.payload.in_plane_count !== want.in_plane_count) begin
          $error("in_plane_count: expected %0d, actual %0d",
                 want.in_plane_count, rsp_ch.payload.in_plane_count);
          fails++;
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             idle_cycles, expected_avgs.size());
      $display("tb_avg_pool_2d_window: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    idle_cycles    = 0;
    stall_left     = 0;
    gaps_on        = 1'b1;
    req_hot        = 1'b0;
    cfg_hot        = 1'b0;
    fails          = 0;
    n_writes       = 0;
    n_computes     = 0;
    n_results      = 0;
    n_settings     = 0;
    cfg_shadow     = '{plane_height: 7'd1, plane_width: 7'd1, kernel_height: 4'd1,
                       kernel_width: 4'd1, stride_rows: 4'd1, stride_cols: 4'd1,
                       pad_top: 3'd0, pad_left: 3'd0};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_sample_extremes();
    test_window_padding();
    test_oversized_settings();
    test_degenerate_settings();
    test_random_windows();
    drain_results(1'b1);

    $display("run covered %0d pixel writes and %0d window averages (%0d checked)",
             n_writes, n_computes, n_results);
    $display("across %0d register settings incl. zero, saturated and all-padding windows",
             n_settings);
    if (fails == 0)
      $display("tb_avg_pool_2d_window: PASS");
    else
      $display("tb_avg_pool_2d_window: FAIL");
    $finish;
  end

endmodule
